// ===== hw/rtl/isf_pkg.sv =====
// Shared constants, types and oscillator lookup for the I/Q frequency shifter.
// The quarter-wave sine table is built here at elaboration time.
// No dependencies.
package isf_pkg;

    // Oscillator and arithmetic sizing
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int COEF_BITS       = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int STEP_BITS       = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam int QUARTER    = 2 ** (TABLE_ADDR_BITS - 2);
    localparam int COEF_SHIFT = COEF_BITS - 1;
    localparam logic [63:0] COEF_SCALE = (64'd1 << COEF_SHIFT) - 64'd1;
    localparam logic [63:0] PI_Q30     = 64'd3373259426;

    // Datapath widths after the complex multiply
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS  = PROD_BITS;
    localparam int EST_BITS  = MAG_BITS + 2;
    localparam int DIV_TERMS = MAG_BITS / COEF_SHIFT + 1;
    localparam int QUOT_BITS = EST_BITS - COEF_SHIFT;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWAP_MODE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTE_SAMPLES = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
    typedef logic signed [COEF_BITS-1:0]     coef_t;
    typedef logic [TABLE_ADDR_BITS-1:0]      tab_idx_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] phase_step;
        logic                 swap_mode;
        logic                 byte_samples;
    } isf_cfg_t;

    // One classified transaction; in swap mode x/y already hold the swapped raw bits
    typedef struct packed {
        logic     swap;
        logic     byte_mode;
        tab_idx_t idx;
        sample_t  x;
        sample_t  y;
    } isf_item_t;

    typedef logic [COEF_BITS-1:0] qwave_t [0:QUARTER];

    // Quarter-wave sine, Q30 Taylor series through x^13, scaled to COEF_SCALE
    function automatic qwave_t build_qwave();
        qwave_t             tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic [63:0]        c;
        logic signed [63:0] sum;
        for (int k = 0; k <= QUARTER; k++) begin
            x   = (64'd2 * PI_Q30 * 64'(k) + (64'd1 << (TABLE_ADDR_BITS - 1)))
                  >> TABLE_ADDR_BITS;
            x2  = (x * x) >> 30;
            mag = x;
            sum = $signed(x);
            for (int n = 1; n <= 6; n++) begin
                mag = ((mag * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - $signed(mag);
                end else begin
                    sum = sum + $signed(mag);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            c = ($unsigned(sum) * COEF_SCALE + (64'd1 << 29)) >> 30;
            if (c > COEF_SCALE) begin
                c = COEF_SCALE;
            end
            tab[k] = c[COEF_BITS-1:0];
        end
        return tab;
    endfunction

    localparam qwave_t QWAVE = build_qwave();

    // Full-wave sine from the quarter table: mirror on odd quadrants, negate on the lower half
    function automatic coef_t sine_at(tab_idx_t idx);
        logic [1:0]                 quad;
        logic [TABLE_ADDR_BITS-3:0] r;
        logic [TABLE_ADDR_BITS-2:0] addr;
        coef_t                      v;
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        r    = idx[TABLE_ADDR_BITS-3:0];
        addr = quad[0] ? ((TABLE_ADDR_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
        v    = $signed(QWAVE[addr]);
        return quad[1] ? -v : v;
    endfunction

endpackage

// ===== hw/rtl/isf_queue.sv =====
// Short FIFO of classified transactions between front and back.
// Depends on isf_pkg.
module isf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  isf_pkg::isf_item_t push_item,
    input  logic               pop,
    output isf_pkg::isf_item_t head_item,
    output logic               full,
    output logic               empty
);
    import isf_pkg::*;

    isf_item_t           entries [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/isf_front.sv =====
// Front end: accepts input transactions, owns the phase accumulator and
// classifies each sample (swap or translate, sample format). Depends on isf_pkg.
module isf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  isf_pkg::isf_cfg_t     cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_in_i,
    input  logic [15:0]           s_in_q,
    input  logic                  q_full,
    output logic                  push,
    output isf_pkg::isf_item_t    push_item
);
    import isf_pkg::*;

    logic [PHASE_BITS-1:0]           phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS+STEP_BITS-1:0] step_wide;
    logic [PHASE_BITS-1:0]           step;
    logic [15:0]                     mask;

    // Step aligned to the accumulator width (scaled up or top bits kept)
    assign step_wide = {cfg.phase_step, PHASE_BITS'(0)};
    assign step      = step_wide[PHASE_BITS+STEP_BITS-1 : STEP_BITS];

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;
    assign mask    = cfg.byte_samples ? 16'h00FF : 16'hFFFF;

    always_comb begin
        push_item.swap      = cfg.swap_mode;
        push_item.byte_mode = cfg.byte_samples;
        push_item.idx       = phase_acc_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        if (cfg.swap_mode) begin
            push_item.x = s_in_q & mask;
            push_item.y = s_in_i & mask;
        end else if (cfg.byte_samples) begin
            // offset binary minus 128 is the byte with its top bit flipped
            push_item.x = {{9{~s_in_i[7]}}, s_in_i[6:0]};
            push_item.y = {{9{~s_in_q[7]}}, s_in_q[6:0]};
        end else begin
            push_item.x = s_in_i;
            push_item.y = s_in_q;
        end
    end

    assign phase_acc_next = push ? phase_acc_reg + step : phase_acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
        end else begin
            phase_acc_reg <= phase_acc_next;
        end
    end

endmodule

// ===== hw/rtl/isf_back.sv =====
// Back end: sine/cosine lookup, complex multiply, divide by the table scale,
// saturation and the output register. Depends on isf_pkg.
module isf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  isf_pkg::isf_item_t head_item,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_out_i,
    output logic [15:0]        m_out_q,
    output logic               m_clipped
);
    import isf_pkg::*;

    typedef struct packed {
        logic    swap;
        logic    byte_mode;
        sample_t x;
        sample_t y;
    } isf_pass_t;

    typedef struct packed {
        logic [15:0] data;
        logic        clip;
    } isf_sat_t;

    function automatic logic [QUOT_BITS-1:0] quot_estimate(logic [MAG_BITS-1:0] mag);
        logic [EST_BITS-1:0] t;
        t = '0;
        for (int j = 0; j < DIV_TERMS; j++) begin
            t = t + EST_BITS'(mag >> (j * COEF_SHIFT));
        end
        return QUOT_BITS'(t >> COEF_SHIFT);
    endfunction

    function automatic logic [QUOT_BITS-1:0] quot_fix(logic [MAG_BITS-1:0] mag,
                                                     logic [QUOT_BITS-1:0] q0);
        logic [EST_BITS-1:0] rem;
        rem = EST_BITS'(mag) + EST_BITS'(q0) - (EST_BITS'(q0) << COEF_SHIFT);
        return (rem >= EST_BITS'(COEF_SCALE)) ? q0 + 1'b1 : q0;
    endfunction

    function automatic isf_sat_t saturate(logic neg, logic [QUOT_BITS-1:0] q,
                                          logic byte_mode);
        isf_sat_t              res;
        logic [QUOT_BITS-1:0]  lim_pos;
        logic [QUOT_BITS-1:0]  lim_neg;
        logic [QUOT_BITS-1:0]  mag_c;
        logic [16:0]           val;
        lim_pos  = byte_mode ? QUOT_BITS'(127) : QUOT_BITS'(32767);
        lim_neg  = byte_mode ? QUOT_BITS'(128) : QUOT_BITS'(32768);
        res.clip = neg ? (q > lim_neg) : (q > lim_pos);
        mag_c    = res.clip ? (neg ? lim_neg : lim_pos) : q;
        val      = neg ? -mag_c[16:0] : mag_c[16:0];
        res.data = byte_mode ? {8'h00, ~val[7], val[6:0]} : val[15:0];
        return res;
    endfunction

    logic advance;

    // stage 1: lookup
    logic      p1_valid_reg;
    isf_pass_t p1_pass_reg;
    coef_t     p1_sin_reg, p1_cos_reg;
    // stage 2: products
    logic      p2_valid_reg;
    isf_pass_t p2_pass_reg;
    logic signed [PROD_BITS-1:0] p2_xc_reg, p2_ys_reg, p2_xs_reg, p2_yc_reg;
    // stage 3: sums
    logic      p3_valid_reg;
    isf_pass_t p3_pass_reg;
    logic signed [SUM_BITS-1:0] p3_u_reg, p3_v_reg;
    // stage 4: sign and magnitude
    logic      p4_valid_reg;
    isf_pass_t p4_pass_reg;
    logic      p4_u_neg_reg, p4_v_neg_reg;
    logic [MAG_BITS-1:0] p4_u_mag_reg, p4_v_mag_reg;
    // stage 5: quotient estimate
    logic      p5_valid_reg;
    isf_pass_t p5_pass_reg;
    logic      p5_u_neg_reg, p5_v_neg_reg;
    logic [MAG_BITS-1:0]  p5_u_mag_reg, p5_v_mag_reg;
    logic [QUOT_BITS-1:0] p5_u_q0_reg, p5_v_q0_reg;
    // stage 6: corrected quotient
    logic      p6_valid_reg;
    isf_pass_t p6_pass_reg;
    logic      p6_u_neg_reg, p6_v_neg_reg;
    logic [QUOT_BITS-1:0] p6_u_q_reg, p6_v_q_reg;
    // output register
    logic        out_valid_reg;
    logic [15:0] out_i_reg, out_q_reg;
    logic        out_clip_reg;

    isf_sat_t  sat_u, sat_v;
    isf_pass_t head_pass;

    // whole pipe moves together unless the output holds an untaken result
    assign advance = !out_valid_reg || m_ready;
    assign pop     = advance && !q_empty;

    assign head_pass = '{swap: head_item.swap, byte_mode: head_item.byte_mode,
                         x: head_item.x, y: head_item.y};

    assign sat_u = saturate(p6_u_neg_reg, p6_u_q_reg, p6_pass_reg.byte_mode);
    assign sat_v = saturate(p6_v_neg_reg, p6_v_q_reg, p6_pass_reg.byte_mode);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg  <= !q_empty;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            p6_valid_reg  <= p5_valid_reg;
            out_valid_reg <= p6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_pass_reg <= head_pass;
            p1_sin_reg  <= sine_at(head_item.idx);
            p1_cos_reg  <= sine_at(head_item.idx + TABLE_ADDR_BITS'(QUARTER));

            p2_pass_reg <= p1_pass_reg;
            p2_xc_reg   <= p1_pass_reg.x * p1_cos_reg;
            p2_ys_reg   <= p1_pass_reg.y * p1_sin_reg;
            p2_xs_reg   <= p1_pass_reg.x * p1_sin_reg;
            p2_yc_reg   <= p1_pass_reg.y * p1_cos_reg;

            p3_pass_reg <= p2_pass_reg;
            p3_u_reg    <= SUM_BITS'(p2_xc_reg) - SUM_BITS'(p2_ys_reg);
            p3_v_reg    <= SUM_BITS'(p2_xs_reg) + SUM_BITS'(p2_yc_reg);

            p4_pass_reg  <= p3_pass_reg;
            p4_u_neg_reg <= p3_u_reg[SUM_BITS-1];
            p4_v_neg_reg <= p3_v_reg[SUM_BITS-1];
            p4_u_mag_reg <= MAG_BITS'(p3_u_reg[SUM_BITS-1] ? -p3_u_reg : p3_u_reg);
            p4_v_mag_reg <= MAG_BITS'(p3_v_reg[SUM_BITS-1] ? -p3_v_reg : p3_v_reg);

            p5_pass_reg  <= p4_pass_reg;
            p5_u_neg_reg <= p4_u_neg_reg;
            p5_v_neg_reg <= p4_v_neg_reg;
            p5_u_mag_reg <= p4_u_mag_reg;
            p5_v_mag_reg <= p4_v_mag_reg;
            p5_u_q0_reg  <= quot_estimate(p4_u_mag_reg);
            p5_v_q0_reg  <= quot_estimate(p4_v_mag_reg);

            p6_pass_reg  <= p5_pass_reg;
            p6_u_neg_reg <= p5_u_neg_reg;
            p6_v_neg_reg <= p5_v_neg_reg;
            p6_u_q_reg   <= quot_fix(p5_u_mag_reg, p5_u_q0_reg);
            p6_v_q_reg   <= quot_fix(p5_v_mag_reg, p5_v_q0_reg);

            if (p6_pass_reg.swap) begin
                out_i_reg    <= p6_pass_reg.x;
                out_q_reg    <= p6_pass_reg.y;
                out_clip_reg <= 1'b0;
            end else begin
                out_i_reg    <= sat_u.data;
                out_q_reg    <= sat_v.data;
                out_clip_reg <= sat_u.clip || sat_v.clip;
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_out_i   = out_i_reg;
    assign m_out_q   = out_q_reg;
    assign m_clipped = out_clip_reg;

endmodule

// ===== hw/rtl/iq_frequency_shifter.sv =====
// Top level of the I/Q frequency shifter: configuration registers, front end,
// transaction queue and arithmetic back end. Depends on isf_pkg, isf_front,
// isf_queue and isf_back.

// Complex NCO mixer for one I/Q sample per transaction. In translate mode each
// sample is rotated by the oscillator angle (phase accumulator top bits into a
// quarter-wave sine table), divided by the table scale with truncation toward
// zero and saturated, with m_clipped set when either component hit the limit.
// In swap mode I and Q are exchanged unchanged. The phase advances by
// phase_step after every transaction in either mode; the first sample after
// reset sees phase zero. With byte_samples set, only the low byte of each
// input is used as offset binary and outputs carry zero high bytes.
// Throughput is one transaction per clock: the accept side is set by a
// 4-entry queue and the back end is a 7-stage pipeline (lookup, multiply,
// add, magnitude, quotient estimate, correction, output register) that stalls
// only while a result sits untaken. Each accepted transaction is queued, then
// passes the stages to m_valid. Configuration writes take effect on the next
// clock and should be made while no transaction is in flight.
module iq_frequency_shifter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_write_en,
    input  logic [isf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [isf_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // sample input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [15:0]                          s_in_i,
    input  logic [15:0]                          s_in_q,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [15:0]                          m_out_i,
    output logic [15:0]                          m_out_q,
    output logic                                 m_clipped
);
    import isf_pkg::*;

    isf_cfg_t  cfg_reg, cfg_next;
    isf_item_t push_item, head_item;
    logic      push, pop, q_full, q_empty;

    // register writes; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write_en) begin
            unique case (cfg_index)
                CFG_PHASE_STEP:   cfg_next.phase_step   = cfg_wdata[STEP_BITS-1:0];
                CFG_SWAP_MODE:    cfg_next.swap_mode    = cfg_wdata[0];
                CFG_BYTE_SAMPLES: cfg_next.byte_samples = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept, phase, classify
    isf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_i    (s_in_i),
        .s_in_q    (s_in_q),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // decouples the input handshake from output backpressure
    isf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: rotate or swap, then present the result
    isf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .head_item (head_item),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_i   (m_out_i),
        .m_out_q   (m_out_q),
        .m_clipped (m_clipped)
    );

endmodule

// ===== dv/tb_iq_frequency_shifter.sv =====
// Self-checking testbench for iq_frequency_shifter: directed corner transactions,
// then randomized phases over phase step, swap and byte modes with random stalls.
// Depends on isf_pkg and the iq_frequency_shifter RTL.
module tb_iq_frequency_shifter;

    localparam int TAB_BITS  = isf_pkg::TABLE_ADDR_BITS;
    localparam int QTR       = 2 ** (TAB_BITS - 2);
    localparam longint SCALE = (64'sd1 <<< (isf_pkg::COEF_BITS - 1)) - 64'sd1;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int DRAIN_CYCLES    = 16;    // margin beyond the pipeline latency
    localparam int QUIET_LIMIT     = 2000;  // cycles with no transaction anywhere

    // Sample corners: both 16-bit extremes, zero, -1, and byte-mode extremes
    localparam logic [15:0] CORNER_SAMPLES [8] = '{
        16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
        16'h0080, 16'h007F, 16'h00FF, 16'hFF00
    };
    localparam logic [31:0] CORNER_STEPS [8] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h4000_0000, 32'hC000_0000, 32'h0040_0000
    };

    // Directed transactions, {in_i, in_q}, grouped by the setting they run under
    localparam logic [31:0] DIRECTED [19] = '{
        // reset settings: phase stays at zero, so the sample comes back as is
        {16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF}, {16'h0000, 16'h0000},
        {16'hFFFF, 16'h0001}, {16'h8000, 16'h8000}, {16'h7FFF, 16'h7FFF},
        // eighth-turn step: 0, 45, 90, 135, 180 degrees -> saturation on both rails
        {16'h8000, 16'h8000}, {16'h8000, 16'h8000}, {16'h7FFF, 16'h8000},
        {16'h8000, 16'h7FFF}, {16'h8000, 16'h0000},
        // byte samples, half-turn step, junk in the high bytes
        {16'hFF00, 16'hFF00}, {16'h12FF, 16'h3400}, {16'h0080, 16'h007F},
        {16'h5500, 16'h0001},
        // swap mode, bytes then words
        {16'hA5C3, 16'h3C5A}, {16'hFFFF, 16'h0000},
        {16'h8000, 16'h7FFF}, {16'h1234, 16'hFEDC}
    };

    // Predicts each rotated or swapped sample and matches it against the DUT
    class mixer_scoreboard;
        typedef struct {
            logic [15:0] out_i;
            logic [15:0] out_q;
            logic        clipped;
        } mixed_sample_t;

        logic [31:0]   phase_step;
        logic          swap_mode;
        logic          byte_samples;
        logic [31:0]   phase_acc;
        longint        quarter_sine [0:QTR];
        mixed_sample_t expected_mix [$];
        int            errors;

        function new();
            longint unsigned ang, sq, term, coef;
            longint          acc;
            phase_step   = '0;
            swap_mode    = 1'b0;
            byte_samples = 1'b0;
            phase_acc    = '0;
            errors       = 0;
            // Q30 Taylor series of sin through x^13, rounded to the coefficient scale
            for (int k = 0; k <= QTR; k++) begin
                ang  = (64'd2 * 64'd3373259426 * longint'(k) + (64'd1 << (TAB_BITS - 1)))
                       >> TAB_BITS;
                sq   = (ang * ang) >> 30;
                term = ang;
                acc  = longint'(ang);
                for (int n = 1; n <= 6; n++) begin
                    term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                coef = (64'(acc) * 64'(SCALE) + (64'd1 << 29)) >> 30;
                if (coef > 64'(SCALE)) begin
                    coef = 64'(SCALE);
                end
                quarter_sine[k] = longint'(coef);
            end
        endfunction

        function longint sine_of(logic [TAB_BITS-1:0] idx);
            logic [1:0]          quad;
            logic [TAB_BITS-3:0] r;
            longint              v;
            quad = idx[TAB_BITS-1 -: 2];
            r    = idx[TAB_BITS-3:0];
            v    = quad[0] ? quarter_sine[QTR - int'(r)] : quarter_sine[r];
            return quad[1] ? -v : v;
        endfunction

        function void configure(logic [isf_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
            case (idx)
                isf_pkg::CFG_PHASE_STEP:   phase_step   = data;
                isf_pkg::CFG_SWAP_MODE:    swap_mode    = data[0];
                isf_pkg::CFG_BYTE_SAMPLES: byte_samples = data[0];
                default: ;
            endcase
        endfunction

        // Input transaction accepted: work out its result, then advance the oscillator
        function void accept_sample(logic [15:0] in_i, logic [15:0] in_q);
            mixed_sample_t       res;
            logic [TAB_BITS-1:0] idx;
            longint              x, y, s, c, u, v, lo, hi;
            res.clipped = 1'b0;
            if (swap_mode) begin
                res.out_i = byte_samples ? {8'h00, in_q[7:0]} : in_q;
                res.out_q = byte_samples ? {8'h00, in_i[7:0]} : in_i;
            end else begin
                idx = phase_acc[31 -: TAB_BITS];
                if (byte_samples) begin
                    x  = longint'(in_i[7:0]) - 128;
                    y  = longint'(in_q[7:0]) - 128;
                    lo = -128;
                    hi = 127;
                end else begin
                    x  = longint'($signed(in_i));
                    y  = longint'($signed(in_q));
                    lo = -32768;
                    hi = 32767;
                end
                s = sine_of(idx);
                c = sine_of(idx + TAB_BITS'(QTR));
                // signed division truncates toward zero
                u = (x * c - y * s) / SCALE;
                v = (x * s + y * c) / SCALE;
                if (u < lo) begin
                    u = lo;
                    res.clipped = 1'b1;
                end else if (u > hi) begin
                    u = hi;
                    res.clipped = 1'b1;
                end
                if (v < lo) begin
                    v = lo;
                    res.clipped = 1'b1;
                end else if (v > hi) begin
                    v = hi;
                    res.clipped = 1'b1;
                end
                if (byte_samples) begin
                    res.out_i = {8'h00, 8'(u + 128)};
                    res.out_q = {8'h00, 8'(v + 128)};
                end else begin
                    res.out_i = 16'(u);
                    res.out_q = 16'(v);
                end
            end
            phase_acc = phase_acc + phase_step;
            expected_mix.push_back(res);
        endfunction

        function void check_mixed(logic [15:0] out_i, logic [15:0] out_q, logic clipped);
            mixed_sample_t exp_res;
            if (expected_mix.size() == 0) begin
                $error("result with no sample outstanding: out_i %h out_q %h clipped %b",
                       out_i, out_q, clipped);
                errors++;
                return;
            end
            exp_res = expected_mix.pop_front();
            if (out_i !== exp_res.out_i) begin
                $error("out_i: expected %h, got %h", exp_res.out_i, out_i);
                errors++;
            end
            if (out_q !== exp_res.out_q) begin
                $error("out_q: expected %h, got %h", exp_res.out_q, out_q);
                errors++;
            end
            if (clipped !== exp_res.clipped) begin
                $error("clipped: expected %b, got %b", exp_res.clipped, clipped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_mix.size();
        endfunction
    endclass

    // All DUT inputs start at known values
    logic                                aclk         = 1'b0;
    logic                                aresetn      = 1'b0;
    logic                                cfg_write_en = 1'b0;
    logic [isf_pkg::CFG_INDEX_BITS-1:0]  cfg_index    = '0;
    logic [isf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata    = '0;
    logic                                s_valid      = 1'b0;
    logic                                s_ready;
    logic [15:0]                         s_in_i       = '0;
    logic [15:0]                         s_in_q       = '0;
    logic                                m_valid;
    logic                                m_ready      = 1'b0;
    logic [15:0]                         m_out_i;
    logic [15:0]                         m_out_q;
    logic                                m_clipped;

    mixer_scoreboard sb;
    logic            steady;        // when set, neither side inserts gaps
    int              quiet_cycles;

    iq_frequency_shifter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_i      (s_in_i),
        .s_in_q      (s_in_q),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_i     (m_out_i),
        .m_out_q     (m_out_q),
        .m_clipped   (m_clipped)
    );

    always #6 aclk = ~aclk;

    // Monitor and watchdog. Values read here are the ones sampled at this edge,
    // since every driver updates through nonblocking assignments.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.accept_sample(s_in_i, s_in_q);
            end
            if (m_valid && m_ready) begin
                sb.check_mixed(m_out_i, m_out_q, m_clipped);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_write_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("iq_frequency_shifter test failed");
                    $finish;
                end
            end
        end
    end

    function automatic int unsigned pick_wait();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    // Mostly uniform words; a fifth of the draws land on a corner value
    function automatic logic [15:0] pick_sample();
        if ($urandom_range(0, 4) == 0) begin
            return CORNER_SAMPLES[$urandom_range(0, 7)];
        end
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_step();
        logic [31:0] mag;
        case ($urandom_range(0, 3))
            0: return CORNER_STEPS[$urandom_range(0, 7)];
            1: begin
                // slow tones, either direction
                mag = $urandom_range(0, 1 << 24);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    // One input transaction. Valid is left high on return so back-to-back
    // transactions never lower and raise it within one step.
    task automatic send_sample(logic [15:0] in_i, logic [15:0] in_q);
        int unsigned gap;
        gap = pick_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_i  <= in_i;
        s_in_q  <= in_q;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic send_directed(int first, int last);
        for (int k = first; k <= last; k++) begin
            send_sample(DIRECTED[k][31:16], DIRECTED[k][15:0]);
        end
    endtask

    task automatic write_reg(logic [isf_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= data;
        @(posedge aclk);
        sb.configure(idx, data);
    endtask

    // Drain everything in flight, then rewrite all three registers. The 1-bit
    // registers get random upper bits, which the block must ignore.
    task automatic reconfigure(logic [31:0] step, logic swap, logic byte_mode);
        logic [31:0] junk;
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        junk = $urandom;
        write_reg(isf_pkg::CFG_PHASE_STEP, step);
        write_reg(isf_pkg::CFG_SWAP_MODE, {junk[31:1], swap});
        junk = $urandom;
        write_reg(isf_pkg::CFG_BYTE_SAMPLES, {junk[31:1], byte_mode});
        cfg_write_en <= 1'b0;
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // Result side: a random stall before each transaction, ready held until taken
    initial begin
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = pick_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        logic [31:0] step;
        logic        swap, byte_mode;
        sb           = new();
        steady       = 1'b0;
        quiet_cycles = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part; the first group runs on reset settings, nothing written
        send_directed(0, 5);
        reconfigure(32'h2000_0000, 1'b0, 1'b0);
        send_directed(6, 10);
        reconfigure(32'h8000_0000, 1'b0, 1'b1);
        send_directed(11, 14);
        reconfigure(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_directed(15, 16);
        reconfigure(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_directed(17, 18);

        // Random phases: step extremes come first, then random settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                step = 32'h8000_0000;
            end else if (p == 1) begin
                step = 32'h7FFF_FFFF;
            end else begin
                step = pick_step();
            end
            if (p < 4) begin
                swap      = (p == 3);
                byte_mode = p[0];
            end else begin
                swap      = ($urandom_range(0, 3) == 0);
                byte_mode = $urandom_range(0, 1);
            end
            reconfigure(step, swap, byte_mode);
            repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), pick_sample());
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("iq_frequency_shifter test passed");
        end else begin
            $display("iq_frequency_shifter test failed");
        end
        $finish;
    end

endmodule
